// ----- sv/packet_stream_deframer_core_assert.svh -----
// assertion macros used by the checker file psd_checker
`ifndef PACKET_STREAM_DEFRAMER_CORE_ASSERT_SVH
`define PACKET_STREAM_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define PSD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ----- sv/psd_pkg.sv -----
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types and constants of the packet stream deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package psd_pkg;

    // parse phases
    typedef enum logic [4:0] {
        PH_CH0  = 5'd0,
        PH_CH1  = 5'd1,
        PH_SPEC = 5'd2,
        PH_HDR0 = 5'd3,
        PH_HDR1 = 5'd4,
        PH_HDR2 = 5'd5,
        PH_HDR3 = 5'd6,
        PH_HDR4 = 5'd7,
        PH_LEN  = 5'd8,
        PH_PAY  = 5'd9,
        PH_CNT0 = 5'd10,
        PH_CNT1 = 5'd11,
        PH_ENT0 = 5'd12,
        PH_ENT1 = 5'd13,
        PH_ENT2 = 5'd14,
        PH_ENT3 = 5'd15,
        PH_ENT4 = 5'd16,
        PH_ENT5 = 5'd17,
        PH_NAME = 5'd18
    } psd_phase_t;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    // error codes
    localparam logic [2:0] ERR_BAD_SPECIAL = 3'd0;
    localparam logic [2:0] ERR_BAD_MAGIC   = 3'd1;
    localparam logic [2:0] ERR_EMPTY_TABLE = 3'd2;
    localparam logic [2:0] ERR_OVER_CAP    = 3'd3;
    localparam logic [2:0] ERR_ILLEGAL_CH  = 3'd4;
    localparam logic [2:0] ERR_DUPLICATE   = 3'd5;
    localparam logic [2:0] ERR_UNKNOWN_CH  = 3'd6;
    localparam logic [2:0] ERR_LEN_OVFL    = 3'd7;

    localparam logic [15:0] SPECIAL_CHANNEL = 16'hFFFF;
    localparam logic [7:0]  SKIP_BYTE       = 8'hFF;
    localparam logic [3:0]  SKIP_LAST_POS   = 4'd3;
    localparam logic [3:0]  MAGIC_LAST_POS  = 4'd13;
    localparam logic [63:0] SKIP_AMOUNT     = 64'h0000_0000_FFFF_FFFF;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] channel_number;
        logic [15:0] major_type;
        logic [7:0]  minor_type;
        logic [63:0] timestamp;
        logic [31:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
        logic [2:0]  error_code;
    } psd_result_t;

    // segment magic, one character per position
    function automatic logic [7:0] magic_byte(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "J";
            4'd1:    c = "P";
            4'd2:    c = "C";
            4'd3:    c = "R";
            4'd4:    c = "R";
            4'd5:    c = "M";
            4'd6:    c = "U";
            4'd7:    c = "L";
            4'd8:    c = "T";
            4'd9:    c = "I";
            4'd10:   c = "D";
            4'd11:   c = "U";
            4'd12:   c = "M";
            4'd13:   c = "P";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- sv/psd_byte_if.sv -----
// ----------------------------------------------------------------------------
// psd_byte_if
// Valid/ready channel carrying one raw stream byte per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- sv/psd_result_if.sv -----
// ----------------------------------------------------------------------------
// psd_result_if
// Valid/ready channel carrying one deframer result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface psd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] channel_number;
    logic [15:0] major_type;
    logic [7:0]  minor_type;
    logic [63:0] timestamp;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        last;
    logic [2:0]  error_code;

    modport source (output valid, output kind, output channel_number, output major_type,
                    output minor_type, output timestamp, output payload_length,
                    output payload_byte, output last, output error_code, input ready);
    modport sink   (input valid, input kind, input channel_number, input major_type,
                    input minor_type, input timestamp, input payload_length,
                    input payload_byte, input last, input error_code, output ready);
endinterface

// ----- sv/packet_stream_deframer_core.sv -----
// ----------------------------------------------------------------------------
// packet_stream_deframer_core
// Byte stream deframer for multiplexed timed packets with channel table.
// ----------------------------------------------------------------------------
// usage
//   byte_in    : one stream byte per item (valid/ready)
//   result_out : packet header, payload byte or error item (valid/ready)
//   each byte is decoded in the cycle it is taken; a result, if any, sits in
//   the output register from the next cycle on
//   throughput is one byte per cycle while byte_in.ready is high; the table
//   lookup is a parallel compare over all TABLE_DEPTH entries in that same cycle
//   byte_in.ready drops only while a result is held and result_out.ready is
//   low, so a stalled receiver stalls the stream by exactly that long
//   reset clears the parser, time base and table count; table contents are
//   not cleared and only entries of the current table are ever looked at
//   after an error item the block keeps taking bytes and drops them all
//   until the next reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_stream_deframer_core #(
    parameter int TABLE_DEPTH = 64,
    parameter int LENGTH_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    psd_byte_if.sink     byte_in,
    psd_result_if.source result_out
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
    localparam logic [CNT_W-1:0] LEN_LIMIT =
        CNT_W'(((64'd1 << LENGTH_BITS) - 64'd1) >> 7);

    // state
    psd_pkg::psd_phase_t phase_reg, phase_next;
    logic [55:0]         hs_reg, hs_next;
    logic [63:0]         time_reg, time_next;
    logic [3:0]          pos_reg, pos_next;
    logic [1:0]          cand_reg, cand_next;
    logic [ENT_W-1:0]    count_reg, count_next;
    logic [ENT_W-1:0]    ent_rem_reg, ent_rem_next;
    logic [CNT_W-1:0]    bytes_reg, bytes_next;
    logic [15:0]         mtype_reg, mtype_next;
    logic                err_reg, err_next;
    logic                out_valid_reg, out_valid_next;
    psd_pkg::psd_result_t out_reg, out_next;

    // channel table
    logic [15:0] tab_ch_reg [TABLE_DEPTH];
    logic [15:0] tab_ty_reg [TABLE_DEPTH];
    logic        tab_we;
    logic [IDX_W-1:0] tab_widx;

    logic        accept;
    logic [7:0]  b;
    logic [55:0] hs_shift;
    logic [55:0] fin_hs;
    logic [15:0] key;
    logic [TABLE_DEPTH-1:0] hit;
    logic        any_hit;
    logic [15:0] hit_type;
    logic        emit;
    psd_pkg::psd_result_t res;
    logic [CNT_W-1:0] len_new;
    logic [15:0] cnt16;
    logic        spec_skip, spec_magic;

    assign byte_in.ready = !out_valid_reg || result_out.ready;
    assign accept        = byte_in.valid && byte_in.ready;
    assign b             = byte_in.data_byte;
    assign hs_shift      = {hs_reg[47:0], b};
    assign fin_hs        = (phase_reg == psd_pkg::PH_ENT5) ? hs_shift : hs_reg;
    assign key           = (phase_reg == psd_pkg::PH_CH1) ? {hs_reg[7:0], b}
                                                           : fin_hs[47:32];
    assign len_new       = CNT_W'({bytes_reg, b[6:0]});
    assign cnt16         = {hs_reg[7:0], b};

    // parallel table compare against the live entries
    always_comb
    begin
        any_hit  = 1'b0;
        hit_type = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit[i]   = (ENT_W'(i) < count_reg) && (tab_ch_reg[i] == key);
            any_hit  = any_hit | hit[i];
            hit_type = hit_type | (tab_ty_reg[i] & {16{hit[i]}});
        end
    end

    // special matching against both candidates
    assign spec_skip  = cand_reg[0] && (pos_reg <= psd_pkg::SKIP_LAST_POS)
                        && (b == psd_pkg::SKIP_BYTE);
    assign spec_magic = cand_reg[1] && (pos_reg <= psd_pkg::MAGIC_LAST_POS)
                        && (b == psd_pkg::magic_byte(pos_reg));

    // parser next state
    always_comb
    begin
        phase_next   = phase_reg;
        hs_next      = hs_reg;
        time_next    = time_reg;
        pos_next     = pos_reg;
        cand_next    = cand_reg;
        count_next   = count_reg;
        ent_rem_next = ent_rem_reg;
        bytes_next   = bytes_reg;
        mtype_next   = mtype_reg;
        err_next     = err_reg;
        tab_we       = 1'b0;
        tab_widx     = count_reg[IDX_W-1:0];
        emit         = 1'b0;
        res          = '0;

        if (accept && !err_reg)
        begin
            unique case (phase_reg)
                psd_pkg::PH_CH0:
                begin
                    hs_next    = {48'd0, b};
                    phase_next = psd_pkg::PH_CH1;
                end
                psd_pkg::PH_CH1:
                begin
                    if (key == psd_pkg::SPECIAL_CHANNEL)
                    begin
                        pos_next   = '0;
                        cand_next  = 2'b11;
                        phase_next = psd_pkg::PH_SPEC;
                    end
                    else if (count_reg == '0)
                    begin
                        emit = 1'b1; res.kind = psd_pkg::KIND_ERROR;
                        res.error_code = psd_pkg::ERR_BAD_MAGIC;
                    end
                    else if (!any_hit)
                    begin
                        emit = 1'b1; res.kind = psd_pkg::KIND_ERROR;
                        res.error_code = psd_pkg::ERR_UNKNOWN_CH;
                    end
                    else
                    begin
                        mtype_next = hit_type;
                        hs_next    = {40'd0, key};
                        phase_next = psd_pkg::PH_HDR0;
                    end
                end
                psd_pkg::PH_SPEC:
                begin
                    if (spec_skip && pos_reg == psd_pkg::SKIP_LAST_POS)
                    begin
                        time_next  = time_reg + psd_pkg::SKIP_AMOUNT;
                        phase_next = psd_pkg::PH_CH0;
                        if (count_reg == '0)
                        begin
                            emit = 1'b1; res.kind = psd_pkg::KIND_ERROR;
                            res.error_code = psd_pkg::ERR_BAD_MAGIC;
                        end
                    end
                    else if (spec_magic && pos_reg == psd_pkg::MAGIC_LAST_POS)
                        phase_next = psd_pkg::PH_CNT0;
                    else if (!spec_skip && !spec_magic)
                    begin
                        emit = 1'b1; res.kind = psd_pkg::KIND_ERROR;
                        res.error_code = psd_pkg::ERR_BAD_SPECIAL;
                    end
                    else
                    begin
                        cand_next = {spec_magic, spec_skip};
                        pos_next  = pos_reg + 4'd1;
                    end
                end
                psd_pkg::PH_HDR0: begin hs_next = hs_shift; phase_next = psd_pkg::PH_HDR1; end
                psd_pkg::PH_HDR1: begin hs_next = hs_shift; phase_next = psd_pkg::PH_HDR2; end
                psd_pkg::PH_HDR2: begin hs_next = hs_shift; phase_next = psd_pkg::PH_HDR3; end
                psd_pkg::PH_HDR3: begin hs_next = hs_shift; phase_next = psd_pkg::PH_HDR4; end
                psd_pkg::PH_HDR4:
                begin
                    hs_next    = hs_shift;
                    bytes_next = '0;
                    phase_next = psd_pkg::PH_LEN;
                end
                psd_pkg::PH_LEN:
                begin
                    if (bytes_reg >= LEN_LIMIT)
                    begin
                        emit = 1'b1; res.kind = psd_pkg::KIND_ERROR;
                        res.error_code = psd_pkg::ERR_LEN_OVFL;
                    end
                    else
                    begin
                        bytes_next = len_new;
                        if (!b[7])
                        begin
                            time_next          = time_reg + {32'd0, hs_reg[39:8]};
                            emit               = 1'b1;
                            res.kind           = psd_pkg::KIND_HEADER;
                            res.channel_number = hs_reg[55:40];
                            res.major_type     = mtype_reg;
                            res.minor_type     = hs_reg[7:0];
                            res.timestamp      = time_next;
                            res.payload_length = 32'(len_new);
                            phase_next = (len_new == '0) ? psd_pkg::PH_CH0 : psd_pkg::PH_PAY;
                        end
                    end
                end
                psd_pkg::PH_PAY:
                begin
                    if (bytes_reg != '0)
                        bytes_next = bytes_reg - 1'b1;
                    emit             = 1'b1;
                    res.kind         = psd_pkg::KIND_PAYLOAD;
                    res.payload_byte = b;
                    res.last         = (bytes_next == '0);
                    if (bytes_next == '0)
                        phase_next = psd_pkg::PH_CH0;
                end
                psd_pkg::PH_CNT0:
                begin
                    hs_next    = {48'd0, b};
                    phase_next = psd_pkg::PH_CNT1;
                end
                psd_pkg::PH_CNT1:
                begin
                    if (cnt16 == 16'd0)
                    begin
                        emit = 1'b1; res.kind = psd_pkg::KIND_ERROR;
                        res.error_code = psd_pkg::ERR_EMPTY_TABLE;
                    end
                    else if (32'(cnt16) > 32'(TABLE_DEPTH))
                    begin
                        emit = 1'b1; res.kind = psd_pkg::KIND_ERROR;
                        res.error_code = psd_pkg::ERR_OVER_CAP;
                    end
                    else
                    begin
                        ent_rem_next = ENT_W'(cnt16);
                        count_next   = '0;
                        phase_next   = psd_pkg::PH_ENT0;
                    end
                end
                psd_pkg::PH_ENT0: begin hs_next = hs_shift; phase_next = psd_pkg::PH_ENT1; end
                psd_pkg::PH_ENT1: begin hs_next = hs_shift; phase_next = psd_pkg::PH_ENT2; end
                psd_pkg::PH_ENT2: begin hs_next = hs_shift; phase_next = psd_pkg::PH_ENT3; end
                psd_pkg::PH_ENT3: begin hs_next = hs_shift; phase_next = psd_pkg::PH_ENT4; end
                psd_pkg::PH_ENT4: begin hs_next = hs_shift; phase_next = psd_pkg::PH_ENT5; end
                psd_pkg::PH_ENT5, psd_pkg::PH_NAME:
                begin
                    if (phase_reg == psd_pkg::PH_ENT5)
                    begin
                        hs_next    = hs_shift;
                        bytes_next = CNT_W'(hs_shift[15:0]);
                    end
                    else if (bytes_reg != '0)
                        bytes_next = bytes_reg - 1'b1;
                    if (bytes_next != '0)
                        phase_next = psd_pkg::PH_NAME;
                    // entry complete
                    else if (fin_hs[47:32] == psd_pkg::SPECIAL_CHANNEL)
                    begin
                        emit = 1'b1; res.kind = psd_pkg::KIND_ERROR;
                        res.error_code = psd_pkg::ERR_ILLEGAL_CH;
                    end
                    else if (any_hit)
                    begin
                        emit = 1'b1; res.kind = psd_pkg::KIND_ERROR;
                        res.error_code = psd_pkg::ERR_DUPLICATE;
                    end
                    else
                    begin
                        if (32'(count_reg) < 32'(TABLE_DEPTH))
                        begin
                            tab_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        if (ent_rem_reg != '0)
                            ent_rem_next = ent_rem_reg - 1'b1;
                        phase_next = (ent_rem_next == '0) ? psd_pkg::PH_CH0
                                                          : psd_pkg::PH_ENT0;
                    end
                end
                default:
                    phase_next = psd_pkg::PH_CH0;
            endcase
            if (emit && res.kind == psd_pkg::KIND_ERROR)
                err_next = 1'b1;
        end
    end

    // output register
    always_comb
    begin
        out_next = out_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (result_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= psd_pkg::PH_CH0;
            hs_reg        <= '0;
            time_reg      <= '0;
            pos_reg       <= '0;
            cand_reg      <= 2'b11;
            count_reg     <= '0;
            ent_rem_reg   <= '0;
            bytes_reg     <= '0;
            mtype_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hs_reg        <= hs_next;
            time_reg      <= time_next;
            pos_reg       <= pos_next;
            cand_reg      <= cand_next;
            count_reg     <= count_next;
            ent_rem_reg   <= ent_rem_next;
            bytes_reg     <= bytes_next;
            mtype_reg     <= mtype_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // table storage
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_ch_reg[tab_widx] <= fin_hs[47:32];
            tab_ty_reg[tab_widx] <= fin_hs[31:16];
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.kind           = out_reg.kind;
    assign result_out.channel_number = out_reg.channel_number;
    assign result_out.major_type     = out_reg.major_type;
    assign result_out.minor_type     = out_reg.minor_type;
    assign result_out.timestamp      = out_reg.timestamp;
    assign result_out.payload_length = out_reg.payload_length;
    assign result_out.payload_byte   = out_reg.payload_byte;
    assign result_out.last           = out_reg.last;
    assign result_out.error_code     = out_reg.error_code;

endmodule

// ----- sv/psd_checker.sv -----
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks of the deframer, bound to packet_stream_deframer_core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_stream_deframer_core_assert.svh"

module psd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] kind,
    input logic       last
);

    // a held result keeps its kind
    `PSD_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(kind))
    // input stalls only behind a blocked result
    `PSD_ASSERT_IMP(a_stall, !in_ready, out_valid && !out_ready)
    // nothing follows a delivered error
    `PSD_ASSERT_NXT(a_err_stop, out_valid && out_ready && kind == psd_pkg::KIND_ERROR, !out_valid)
    // last only on payload items, kind never unused
    `PSD_ASSERT_IMP(a_last, out_valid && kind != psd_pkg::KIND_PAYLOAD, !last && kind <= psd_pkg::KIND_ERROR)

endmodule

bind packet_stream_deframer_core psd_checker u_psd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (byte_in.valid),
    .in_ready  (byte_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .kind      (result_out.kind),
    .last      (result_out.last)
);

// ----- dv/psd_deframer_checker.sv -----
// ----------------------------------------------------------------------------
// psd_deframer_checker
// Watches the byte and result channels of the deframer, decodes every
// accepted byte with its own parser model and compares each result item
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_deframer_checker #(
    parameter int TABLE_DEPTH = 64,
    parameter int LENGTH_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    psd_byte_if   byte_mon,
    psd_result_if res_mon,
    output int    fail_count,
    output int    pending
);

    localparam logic [63:0] LEN_LIMIT = ((64'd1 << LENGTH_BITS) - 64'd1) >> 7;

    // parser state
    psd_pkg::psd_phase_t phase;
    logic [55:0] hshift;
    logic [63:0] tacc;
    logic [3:0]  spos;
    logic [1:0]  cand;
    logic [15:0] tab_ch [TABLE_DEPTH];
    logic [15:0] tab_ty [TABLE_DEPTH];
    int          tcount;
    int          ent_rem;
    logic [63:0] brem;
    int          mslot;
    bit          stopped;

    psd_pkg::psd_result_t expected_q [$];

    assign pending = expected_q.size();

    task automatic raise(input logic [2:0] code);
        psd_pkg::psd_result_t r;
        r = '0;
        r.kind = psd_pkg::KIND_ERROR;
        r.error_code = code;
        stopped = 1'b1;
        expected_q.push_back(r);
    endtask

    // close one table entry: check it, then store it
    task automatic close_entry();
        logic [15:0] ch;
        ch = hshift[47:32];
        if (ch == psd_pkg::SPECIAL_CHANNEL)
        begin
            raise(psd_pkg::ERR_ILLEGAL_CH);
            return;
        end
        for (int i = 0; i < tcount; i++)
            if (tab_ch[i] == ch)
            begin
                raise(psd_pkg::ERR_DUPLICATE);
                return;
            end
        if (tcount < TABLE_DEPTH)
        begin
            tab_ch[tcount] = ch;
            tab_ty[tcount] = hshift[31:16];
            tcount++;
        end
        if (ent_rem > 0)
            ent_rem--;
        phase = (ent_rem == 0) ? psd_pkg::PH_CH0 : psd_pkg::PH_ENT0;
    endtask

    // decode one accepted stream byte
    task automatic decode_byte(input logic [7:0] b);
        logic [15:0] ch;
        logic [1:0]  alive;
        bit          found;
        psd_pkg::psd_result_t r;
        r = '0;
        if (stopped)
            return;
        case (phase)
            psd_pkg::PH_CH0:
            begin
                hshift = {48'd0, b};
                phase = psd_pkg::PH_CH1;
            end
            psd_pkg::PH_CH1:
            begin
                ch = {hshift[7:0], b};
                if (ch == psd_pkg::SPECIAL_CHANNEL)
                begin
                    spos = '0;
                    cand = 2'b11;
                    phase = psd_pkg::PH_SPEC;
                end
                else if (tcount == 0)
                    raise(psd_pkg::ERR_BAD_MAGIC);
                else
                begin
                    found = 0;
                    for (int i = 0; i < tcount && !found; i++)
                        if (tab_ch[i] == ch)
                        begin
                            found = 1;
                            mslot = i;
                        end
                    if (!found)
                        raise(psd_pkg::ERR_UNKNOWN_CH);
                    else
                    begin
                        hshift = {40'd0, ch};
                        phase = psd_pkg::PH_HDR0;
                    end
                end
            end
            psd_pkg::PH_SPEC:
            begin
                alive = 2'b00;
                if (cand[0] && spos < 4 && b == psd_pkg::SKIP_BYTE)
                begin
                    if (spos == psd_pkg::SKIP_LAST_POS)
                    begin
                        tacc += psd_pkg::SKIP_AMOUNT;
                        phase = psd_pkg::PH_CH0;
                        if (tcount == 0)
                            raise(psd_pkg::ERR_BAD_MAGIC);
                        return;
                    end
                    alive[0] = 1'b1;
                end
                if (cand[1] && spos < 14 && b == psd_pkg::magic_byte(spos))
                begin
                    if (spos == psd_pkg::MAGIC_LAST_POS)
                    begin
                        phase = psd_pkg::PH_CNT0;
                        return;
                    end
                    alive[1] = 1'b1;
                end
                if (alive == 2'b00)
                    raise(psd_pkg::ERR_BAD_SPECIAL);
                else
                begin
                    cand = alive;
                    spos = spos + 4'd1;
                end
            end
            psd_pkg::PH_HDR0, psd_pkg::PH_HDR1, psd_pkg::PH_HDR2, psd_pkg::PH_HDR3,
            psd_pkg::PH_HDR4:
            begin
                hshift = {hshift[47:0], b};
                if (phase == psd_pkg::PH_HDR4)
                begin
                    brem = '0;
                    phase = psd_pkg::PH_LEN;
                end
                else
                    phase = psd_pkg::psd_phase_t'(phase + 5'd1);
            end
            psd_pkg::PH_LEN:
            begin
                if (brem >= LEN_LIMIT)
                    raise(psd_pkg::ERR_LEN_OVFL);
                else
                begin
                    brem = {brem[56:0], b[6:0]};
                    if (!b[7])
                    begin
                        tacc += {32'd0, hshift[39:8]};
                        r.kind = psd_pkg::KIND_HEADER;
                        r.channel_number = hshift[55:40];
                        r.major_type = tab_ty[mslot];
                        r.minor_type = hshift[7:0];
                        r.timestamp = tacc;
                        r.payload_length = brem[31:0];
                        expected_q.push_back(r);
                        phase = (brem == 0) ? psd_pkg::PH_CH0 : psd_pkg::PH_PAY;
                    end
                end
            end
            psd_pkg::PH_PAY:
            begin
                if (brem > 0)
                    brem--;
                r.kind = psd_pkg::KIND_PAYLOAD;
                r.payload_byte = b;
                r.last = (brem == 0);
                expected_q.push_back(r);
                if (brem == 0)
                    phase = psd_pkg::PH_CH0;
            end
            psd_pkg::PH_CNT0:
            begin
                hshift = {48'd0, b};
                phase = psd_pkg::PH_CNT1;
            end
            psd_pkg::PH_CNT1:
            begin
                ch = {hshift[7:0], b};
                if (ch == 0)
                    raise(psd_pkg::ERR_EMPTY_TABLE);
                else if (int'(ch) > TABLE_DEPTH)
                    raise(psd_pkg::ERR_OVER_CAP);
                else
                begin
                    ent_rem = int'(ch);
                    tcount = 0;
                    phase = psd_pkg::PH_ENT0;
                end
            end
            psd_pkg::PH_ENT0, psd_pkg::PH_ENT1, psd_pkg::PH_ENT2, psd_pkg::PH_ENT3,
            psd_pkg::PH_ENT4, psd_pkg::PH_ENT5:
            begin
                hshift = {hshift[47:0], b};
                if (phase != psd_pkg::PH_ENT5)
                    phase = psd_pkg::psd_phase_t'(phase + 5'd1);
                else
                begin
                    brem = {48'd0, hshift[15:0]};
                    if (brem == 0)
                        close_entry();
                    else
                        phase = psd_pkg::PH_NAME;
                end
            end
            psd_pkg::PH_NAME:
            begin
                if (brem > 0)
                    brem--;
                if (brem == 0)
                    close_entry();
            end
            default:
                phase = psd_pkg::PH_CH0;
        endcase
    endtask

    function automatic int field_bad(input string name, input logic [63:0] e,
                                     input logic [63:0] a);
        if (e === a)
            return 0;
        $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, e, a);
        return 1;
    endfunction

    // compare one accepted result item with the oldest prediction
    task automatic compare_item();
        psd_pkg::psd_result_t e;
        int bad;
        if (expected_q.size() == 0)
        begin
            $display("%0t: unexpected result item, kind %0d", $time, res_mon.kind);
            fail_count++;
            return;
        end
        e = expected_q.pop_front();
        bad = 0;
        bad += field_bad("kind", 64'(e.kind), 64'(res_mon.kind));
        bad += field_bad("channel_number", 64'(e.channel_number),
                         64'(res_mon.channel_number));
        bad += field_bad("major_type", 64'(e.major_type), 64'(res_mon.major_type));
        bad += field_bad("minor_type", 64'(e.minor_type), 64'(res_mon.minor_type));
        bad += field_bad("timestamp", e.timestamp, res_mon.timestamp);
        bad += field_bad("payload_length", 64'(e.payload_length),
                         64'(res_mon.payload_length));
        bad += field_bad("payload_byte", 64'(e.payload_byte), 64'(res_mon.payload_byte));
        bad += field_bad("last", 64'(e.last), 64'(res_mon.last));
        bad += field_bad("error_code", 64'(e.error_code), 64'(res_mon.error_code));
        if (bad != 0)
            fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        phase = psd_pkg::PH_CH0;
        hshift = '0;
        tacc = '0;
        spos = '0;
        cand = 2'b11;
        tcount = 0;
        ent_rem = 0;
        brem = '0;
        mslot = 0;
        stopped = 0;
    end

    // results are checked before the byte of the same edge is decoded
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_mon.valid && res_mon.ready)
                compare_item();
            if (byte_mon.valid && byte_mon.ready)
                decode_byte(byte_mon.data_byte);
        end
    end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the packet stream deframer: channel tables, timed packets,
// timeskips and one closing error case, with bursty input and a stalling
// receiver. Checking is done by psd_deframer_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int BYTE_TARGET = 1050;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cyc;
    int   sent;
    int   burst_left;
    bit   hold_trigger;
    logic [15:0] chans [$];

    psd_byte_if   byte_ch ();
    psd_result_if res_ch ();

    packet_stream_deframer_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .result_out (res_ch)
    );

    psd_deframer_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_mon   (byte_ch),
        .res_mon    (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = 8'h00;
        res_ch.ready = 1'b0;
    end

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random ready pattern plus one long hold-off
    initial
    begin
        int mode_left;
        int pct;
        int hold_left;
        bit hold_done;
        mode_left = 0;
        pct = 100;
        hold_left = 0;
        hold_done = 0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                res_ch.ready = 1'b0;
                hold_left--;
            end
            else if (hold_trigger && !hold_done)
            begin
                hold_done = 1;
                hold_left = 300;
                res_ch.ready = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(16, 96);
                    pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(20, 90);
                end
                mode_left--;
                res_ch.ready = ($urandom_range(1, 100) <= pct);
            end
        end
    end

    // offer one byte, in bursts with random gaps
    task automatic send(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                byte_ch.valid = 1'b0;
            end
        end
        @(negedge clk);
        byte_ch.valid = 1'b1;
        byte_ch.data_byte = b;
        burst_left--;
        sent++;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
    endtask

    task automatic send16(input logic [15:0] v);
        send(v[15:8]);
        send(v[7:0]);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic send_magic();
        send16(psd_pkg::SPECIAL_CHANNEL);
        for (int k = 0; k <= int'(psd_pkg::MAGIC_LAST_POS); k++)
            send(psd_pkg::magic_byte(4'(k)));
    endtask

    task automatic send_timeskip();
        send16(psd_pkg::SPECIAL_CHANNEL);
        repeat (4)
            send(psd_pkg::SKIP_BYTE);
    endtask

    function automatic bit known_chan(input logic [15:0] c);
        foreach (chans[i])
            if (chans[i] == c)
                return 1;
        return 0;
    endfunction

    function automatic logic [15:0] fresh_chan();
        logic [15:0] c;
        do
            c = 16'($urandom_range(0, 16'hFFFE));
        while (known_chan(c));
        return c;
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // one table entry; name bytes are skipped by the block
    task automatic send_entry(input logic [15:0] c, input logic [15:0] ty);
        int nlen;
        nlen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
        send16(c);
        send16(ty);
        send16(16'(nlen));
        repeat (nlen)
            send(8'($urandom));
    endtask

    // new table of n entries with distinct channels
    task automatic send_table(input int n, input bit with_extremes);
        logic [15:0] c;
        send_magic();
        send16(16'(n));
        chans.delete();
        for (int i = 0; i < n; i++)
        begin
            if (with_extremes && i == 0 && n > 1)
                c = 16'h0000;
            else if (with_extremes && i == 1)
                c = 16'hFFFE;
            else
                c = fresh_chan();
            chans.push_back(c);
            send_entry(c, pick16());
        end
    endtask

    // base-128 length, most significant group first
    task automatic send_len(input int unsigned n, input bit padded);
        logic [6:0] grp [$];
        do
        begin
            grp.push_front(n[6:0]);
            n = n >> 7;
        end
        while (n != 0);
        if (padded)
            send(8'h80);
        foreach (grp[i])
            send({(i != grp.size() - 1), grp[i]});
    endtask

    task automatic send_packet(input logic [15:0] c, input logic [31:0] delta,
                               input logic [7:0] minor, input int unsigned len,
                               input bit padded);
        send16(c);
        send(delta[31:24]);
        send(delta[23:16]);
        send(delta[15:8]);
        send(delta[7:0]);
        send(minor);
        send_len(len, padded);
        repeat (len)
            send(8'($urandom));
    endtask

    task automatic random_packet();
        logic [31:0] delta;
        int unsigned len;
        int r;
        r = $urandom_range(0, 9);
        delta = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
        r = $urandom_range(0, 99);
        len = (r < 70) ? $urandom_range(0, 8) :
              (r < 95) ? $urandom_range(9, 40) : $urandom_range(128, 300);
        send_packet(chans[$urandom_range(0, chans.size() - 1)], delta,
                    ($urandom_range(0, 7) == 0) ? 8'hFF : 8'($urandom), len,
                    ($urandom_range(0, 9) == 0));
    endtask

    // closing error case; the block drops everything after it
    task automatic send_error_case();
        logic [15:0] c;
        int k;
        case ($urandom_range(0, 6))
            0:
            begin
                send16(psd_pkg::SPECIAL_CHANNEL);
                k = $urandom_range(0, 13);
                for (int i = 0; i < k; i++)
                    send(psd_pkg::magic_byte(4'(i)));
                send((k == 0) ? 8'h00 : "X");
            end
            1:
            begin
                send_magic();
                send16(16'h0000);
            end
            2:
            begin
                send_magic();
                send16(($urandom_range(0, 1) == 0) ? 16'hFFFF :
                       16'($urandom_range(65, 16'hFFFE)));
            end
            3:
            begin
                send_magic();
                send16(16'd2);
                send_entry(fresh_chan(), pick16());
                send_entry(psd_pkg::SPECIAL_CHANNEL, pick16());
            end
            4:
            begin
                send_magic();
                send16(16'd3);
                c = fresh_chan();
                send_entry(c, pick16());
                send_entry(fresh_chan(), pick16());
                send_entry(c, pick16());
            end
            5:
                send_packet(fresh_chan(), $urandom, 8'($urandom), 0, 0);
            default:
            begin
                send16(chans[0]);
                repeat (5)
                    send(8'($urandom));
                repeat (6)
                    send(8'hFF);
            end
        endcase
        repeat (20)
            send(8'($urandom));
    endtask

    // main stimulus
    initial
    begin
        int r;
        cyc = 0;
        sent = 0;
        burst_left = 0;
        hold_trigger = 0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // now and then the run opens with no table at all
        if ($urandom_range(0, 15) == 0)
        begin
            if ($urandom_range(0, 1) == 0)
                send_timeskip();
            else
                send_packet(16'h0001, 32'h1, 8'h0, 1, 0);
        end

        // directed: small table with extreme channels and types
        send_table(3, 1);
        send_packet(16'h0000, 32'h0, 8'h00, 0, 0);
        send_packet(16'hFFFE, 32'hFFFF_FFFF, 8'hFF, 3, 1);
        send_timeskip();
        send_packet(chans[2], 32'h8000_0001, 8'h5A, 130, 0);
        wait_drained();
        send_table(64, 1);
        random_packet();
        wait_drained();

        // random: mostly packets, some tables and timeskips
        while (sent < BYTE_TARGET)
        begin
            if (sent > BYTE_TARGET / 2)
                hold_trigger = 1;
            r = $urandom_range(0, 99);
            if (r < 85)
                random_packet();
            else if (r < 92)
                send_timeskip();
            else
                send_table(($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) :
                           $urandom_range(1, 8), 1'($urandom_range(0, 1)));
        end

        hold_trigger = 1;
        send_error_case();
        wait_drained();
        repeat (20)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
